/* rtl/minimap_blip_projector_core_defines.svh */
// Assertion macros for the minimap blip projector.
// Used by the checker; depends on nothing.
`ifndef MINIMAP_BLIP_PROJECTOR_CORE_DEFINES_SVH
`define MINIMAP_BLIP_PROJECTOR_CORE_DEFINES_SVH

// Checked only out of reset.
`define MBP_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("mbp check failed");

// Checked at every edge, reset included.
`define MBP_ASSERT_ALWAYS(lbl, ck, prop) \
    lbl: assert property (@(posedge ck) prop) else $error("mbp check failed");

`endif

/* rtl/mbp_pkg.sv */
// Package for the minimap blip projector: types, constants, arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package mbp_pkg;

    localparam int CORDIC_STEPS = 16;   // 8 .. 24
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [16:0] INV_GAIN = 17'sd39797;

    localparam int PADDR_W = 4;

    // register index = paddr[3:2]
    localparam logic [1:0] REG_MAP_RADIUS = 2'd0;
    localparam logic [1:0] REG_CENTER_X   = 2'd1;
    localparam logic [1:0] REG_CENTER_Y   = 2'd2;

    localparam logic [9:0] MAP_RADIUS_RST = 10'd64;

    typedef struct packed {
        logic               valid;
        logic               kind;
        logic [15:0]        yaw;
        logic signed [27:0] x;
        logic signed [27:0] y;
        logic [31:0]        ang;
    } vec_stage_t;

    typedef struct packed {
        logic               valid;
        logic               kind;
        logic signed [20:0] x;
        logic signed [20:0] y;
        logic signed [31:0] z;
    } rot_stage_t;

    function automatic logic [31:0] atan_of(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/mbp_if.sv */
// Valid/ready channel interfaces for blip input and icon output words.
// No dependencies.
`timescale 1ns / 1ps

interface mbp_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [23:0] player_x;
    logic signed [23:0] player_z;
    logic [15:0]        player_yaw;
    logic signed [23:0] entity_x;
    logic signed [23:0] entity_z;

    modport source (output valid, kind, player_x, player_z, player_yaw,
                    entity_x, entity_z, input ready);
    modport sink   (input valid, kind, player_x, player_z, player_yaw,
                    entity_x, entity_z, output ready);
endinterface

interface mbp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] icon_x;
    logic signed [15:0] icon_y;
    logic               icon_kind;

    modport source (output valid, icon_x, icon_y, icon_kind, input ready);
    modport sink   (input valid, icon_x, icon_y, icon_kind, output ready);
endinterface

/* rtl/mbp_vec_cell.sv */
// One vectoring CORDIC micro-rotation with its stage register.
// Depends on mbp_pkg.
`timescale 1ns / 1ps

module mbp_vec_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [4:0]         sh,
    input  logic [31:0]        atan_val,
    input  mbp_pkg::vec_stage_t cur,
    output mbp_pkg::vec_stage_t nxt
);
    import mbp_pkg::*;

    vec_stage_t stage_reg, stage_next;
    logic signed [27:0] xs, ys;

    always_comb
    begin
        xs = cur.x >>> sh;
        ys = cur.y >>> sh;
        stage_next = cur;
        if (!cur.y[27])
        begin
            stage_next.x   = cur.x + ys;
            stage_next.y   = cur.y - xs;
            stage_next.ang = cur.ang + atan_val;
        end
        else
        begin
            stage_next.x   = cur.x - ys;
            stage_next.y   = cur.y + xs;
            stage_next.ang = cur.ang - atan_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (en)
            stage_reg <= stage_next;
    end

    assign nxt = stage_reg;

endmodule

/* rtl/mbp_rot_cell.sv */
// One rotating CORDIC micro-rotation with its stage register.
// Depends on mbp_pkg.
`timescale 1ns / 1ps

module mbp_rot_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [4:0]         sh,
    input  logic [31:0]        atan_val,
    input  mbp_pkg::rot_stage_t cur,
    output mbp_pkg::rot_stage_t nxt
);
    import mbp_pkg::*;

    rot_stage_t stage_reg, stage_next;
    logic signed [20:0] xs, ys;

    always_comb
    begin
        xs = cur.x >>> sh;
        ys = cur.y >>> sh;
        stage_next = cur;
        if (!cur.z[31])
        begin
            stage_next.x = cur.x - ys;
            stage_next.y = cur.y + xs;
            stage_next.z = cur.z - $signed(atan_val);
        end
        else
        begin
            stage_next.x = cur.x + ys;
            stage_next.y = cur.y - xs;
            stage_next.z = cur.z + $signed(atan_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (en)
            stage_reg <= stage_next;
    end

    assign nxt = stage_reg;

endmodule

/* rtl/minimap_blip_projector_core.sv */
// Minimap blip projector top level: front stage, two CORDIC cell chains,
// gain and saturation stages. Depends on mbp_pkg, mbp_if, mbp_vec_cell, mbp_rot_cell.
//
// Usage
//   blip_in  : one word per entity (player pos/yaw, entity pos, kind), valid/ready.
//   blip_out : one icon word per input word, in order (icon_x, icon_y Q13.3, kind).
//   APB      : map_radius at 0x0, center_x at 0x4, center_y at 0x8; write only
//              while the pipe is empty. pready is tied high, reads return the register.
// Stages     : from accept to the word showing on blip_out, in order: front,
//              vectoring chain, gain multiply, clamp/quadrant set-up, rotation
//              chain, gain multiply, saturate.
// Throughput : one word per cycle when not stalled; every stage is a register
//              in a single enable-driven pipe, one cell per CORDIC micro-rotation.
// Stall      : the whole pipe holds while the output register is full and not
//              taken, so blip_in.ready drops in that same cycle.
// Reset      : rst_n (async, active low) clears every stage valid bit and
//              loads map_radius = 64, centre = (0, 0).
`timescale 1ns / 1ps

module minimap_blip_projector_core (
    input  logic                        clk,
    input  logic                        rst_n,
    mbp_in_if.sink                      blip_in,
    mbp_out_if.source                   blip_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mbp_pkg::*;

    // ---------------- configuration registers ----------------
    logic [9:0]         map_radius_reg;
    logic signed [11:0] center_x_reg;
    logic signed [11:0] center_y_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_radius_reg <= MAP_RADIUS_RST;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MAP_RADIUS: map_radius_reg <= pwdata[9:0];
                REG_CENTER_X:   center_x_reg   <= pwdata[11:0];
                REG_CENTER_Y:   center_y_reg   <= pwdata[11:0];
                default: ;      // unmapped, ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MAP_RADIUS: prdata = {22'd0, map_radius_reg};
            REG_CENTER_X:   prdata = {{20{center_x_reg[11]}}, center_x_reg};
            REG_CENTER_Y:   prdata = {{20{center_y_reg[11]}}, center_y_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- pipe enable ----------------
    // Single enable: the pipe moves unless the output word is stuck.
    logic out_valid_reg;
    logic en;

    assign en            = !out_valid_reg || blip_out.ready;
    assign blip_in.ready = en;

    // ---------------- front stage: player-to-entity vector ----------------
    // Vector pointing into the left half is negated and starts at a half turn.
    vec_stage_t         vec_pipe [0:CORDIC_STEPS];
    vec_stage_t         front_next;
    logic signed [24:0] dx, dy;

    always_comb
    begin
        dx = 25'(blip_in.player_x) - 25'(blip_in.entity_x);
        dy = 25'(blip_in.player_z) - 25'(blip_in.entity_z);
        front_next.valid = blip_in.valid;
        front_next.kind  = blip_in.kind;
        front_next.yaw   = blip_in.player_yaw;
        if (dx[24])
        begin
            front_next.x   = -28'(dx);
            front_next.y   = -28'(dy);
            front_next.ang = 32'h8000_0000;
        end
        else
        begin
            front_next.x   = 28'(dx);
            front_next.y   = 28'(dy);
            front_next.ang = 32'd0;
        end
    end

    vec_stage_t front_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_reg <= '0;
        else if (en)
            front_reg <= front_next;
    end

    assign vec_pipe[0] = front_reg;

    // ---------------- vectoring chain ----------------
    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STEPS; gi++)
        begin : g_vec
            mbp_vec_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .sh       (5'(gi)),
                .atan_val (atan_of(gi)),
                .cur      (vec_pipe[gi]),
                .nxt      (vec_pipe[gi+1])
            );
        end
    endgenerate

    // ---------------- length gain multiply ----------------
    // x is never negative here; product is x * 0.607 in Q16.
    logic               gm_valid_reg;
    logic               gm_kind_reg;
    logic [15:0]        gm_yaw_reg;
    logic [31:0]        gm_ang_reg;
    logic signed [44:0] gm_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gm_valid_reg <= 1'b0;
        else if (en)
            gm_valid_reg <= vec_pipe[CORDIC_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gm_kind_reg <= vec_pipe[CORDIC_STEPS].kind;
            gm_yaw_reg  <= vec_pipe[CORDIC_STEPS].yaw;
            gm_ang_reg  <= vec_pipe[CORDIC_STEPS].ang;
            gm_prod_reg <= 45'(vec_pipe[CORDIC_STEPS].x) * 45'(INV_GAIN);
        end
    end

    // ---------------- clamp and rotation set-up ----------------
    // d = prod / 2^18 in Q.8 pixels, clamped to radius*256. Angles in the
    // left half start from (-d, 0) with a half turn folded in.
    rot_stage_t         rot_pipe [0:CORDIC_STEPS];
    rot_stage_t         setup_next, setup_reg;
    logic [26:0]        d_raw;
    logic [17:0]        d_lim;
    logic [17:0]        d_clamp;
    logic [31:0]        rang;

    always_comb
    begin
        d_raw   = gm_prod_reg[44:18];
        d_lim   = {map_radius_reg, 8'd0};
        d_clamp = (d_raw >= 27'(d_lim)) ? d_lim : d_raw[17:0];
        rang    = gm_ang_reg + {gm_yaw_reg, 16'd0} + 32'h8000_0000;
        setup_next.valid = gm_valid_reg;
        setup_next.kind  = gm_kind_reg;
        setup_next.y     = '0;
        if (rang[31:30] == 2'd1 || rang[31:30] == 2'd2)
        begin
            setup_next.x = -21'(d_clamp);
            setup_next.z = $signed(rang + 32'h8000_0000);
        end
        else
        begin
            setup_next.x = 21'(d_clamp);
            setup_next.z = $signed(rang);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            setup_reg <= '0;
        else if (en)
            setup_reg <= setup_next;
    end

    assign rot_pipe[0] = setup_reg;

    // ---------------- rotation chain ----------------
    generate
        for (gi = 0; gi < CORDIC_STEPS; gi++)
        begin : g_rot
            mbp_rot_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .sh       (5'(gi)),
                .atan_val (atan_of(gi)),
                .cur      (rot_pipe[gi]),
                .nxt      (rot_pipe[gi+1])
            );
        end
    endgenerate

    // ---------------- coordinate gain multiply ----------------
    logic               cm_valid_reg;
    logic               cm_kind_reg;
    logic signed [37:0] cm_x_reg, cm_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cm_valid_reg <= 1'b0;
        else if (en)
            cm_valid_reg <= rot_pipe[CORDIC_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cm_kind_reg <= rot_pipe[CORDIC_STEPS].kind;
            cm_x_reg    <= 38'(rot_pipe[CORDIC_STEPS].x) * 38'(INV_GAIN);
            cm_y_reg    <= 38'(rot_pipe[CORDIC_STEPS].y) * 38'(INV_GAIN);
        end
    end

    // ---------------- centre offset, saturate, output word ----------------
    logic signed [18:0] sum_x, sum_y;
    logic signed [15:0] sat_x, sat_y;
    logic signed [15:0] icon_x_reg, icon_y_reg;
    logic               icon_kind_reg;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        logic signed [15:0] r;
        if (v > 19'sd32767)
            r = 16'sh7fff;
        else if (v < -19'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // centre * 8 is sign-extended before the add
    always_comb
    begin
        sum_x = 19'(cm_x_reg >>> 21) + 19'($signed({center_x_reg, 3'd0}));
        sum_y = 19'(cm_y_reg >>> 21) + 19'($signed({center_y_reg, 3'd0}));
        sat_x = sat16(sum_x);
        sat_y = sat16(sum_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= cm_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            icon_x_reg    <= sat_x;
            icon_y_reg    <= sat_y;
            icon_kind_reg <= cm_kind_reg;
        end
    end

    assign blip_out.valid     = out_valid_reg;
    assign blip_out.icon_x    = icon_x_reg;
    assign blip_out.icon_y    = icon_y_reg;
    assign blip_out.icon_kind = icon_kind_reg;

endmodule

/* rtl/mbp_checker.sv */
// Port-level checks for the minimap blip projector, bound to the top level.
// Depends on minimap_blip_projector_core_defines.svh.
`timescale 1ns / 1ps
`include "minimap_blip_projector_core_defines.svh"

module mbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] icon_x,
    input logic [15:0] icon_y,
    input logic        icon_kind,
    input logic        pready
);

    // a stuck output word must hold the input side off
    `MBP_ASSERT(a_stall_blocks_in, clk, rst_n, (out_valid && !out_ready) |-> !in_ready)
    // a stalled word keeps its payload
    `MBP_ASSERT(a_stall_holds, clk, rst_n, (out_valid && !out_ready) |=> ($stable(icon_x) && $stable(icon_y) && $stable(icon_kind)))
    // empty output lets input in
    `MBP_ASSERT(a_empty_takes, clk, rst_n, !out_valid |-> in_ready)
    // no word once reset has been seen
    `MBP_ASSERT_ALWAYS(a_reset_quiet, clk, (!rst_n |=> !out_valid) and pready)

endmodule

bind minimap_blip_projector_core mbp_checker u_mbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (blip_in.ready),
    .out_valid (blip_out.valid),
    .out_ready (blip_out.ready),
    .icon_x    (blip_out.icon_x),
    .icon_y    (blip_out.icon_y),
    .icon_kind (blip_out.icon_kind),
    .pready    (pready)
);
